// ----- hdl/tsm_pkg.sv -----
// ----------------------------------------------------------------------------
// Two stacks in shared memory: common types and constants
// Command and status codes and the width of the capacity write field.
// ----------------------------------------------------------------------------
package tsm_pkg;

  localparam int unsigned CAP_W = 11;
  localparam int unsigned OUT_W = 32;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic {
    SEL_LOW  = 1'b0,
    SEL_HIGH = 1'b1
  } sel_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

endpackage

// ----- hdl/tsm_if.sv -----
// ----------------------------------------------------------------------------
// Two stacks in shared memory: channel interfaces
// Command channel, result channel and capacity write channel.
// ----------------------------------------------------------------------------
interface tsm_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic        stack_sel;
  logic [31:0] push_value;

  modport source (output valid, output cmd, output stack_sel, output push_value,
                  input ready);
  modport sink (input valid, input cmd, input stack_sel, input push_value,
                output ready);
endinterface

interface tsm_out_if;
  logic             valid;
  logic             ready;
  logic [31:0]      pop_value;
  tsm_pkg::status_e status;

  modport source (output valid, output pop_value, output status, input ready);
  modport sink (input valid, input pop_value, input status, output ready);
endinterface

interface tsm_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [tsm_pkg::CAP_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

// ----- hdl/tsm_ram.sv -----
// ----------------------------------------------------------------------------
// Two stacks in shared memory: single-port RAM
// Generic synchronous RAM with one read or write per cycle and registered read.
// ----------------------------------------------------------------------------
module tsm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/two_stacks_shared_memory.sv -----
// ----------------------------------------------------------------------------
// Two stacks in shared memory: top level
// A result word is valid in the cycle after its command word is accepted.
// Throughput: one command word per cycle while the result side takes each word;
// the single RAM port does one access per command and sets that figure.
// Reset: both stacks empty, capacity equal to the smaller of 1024 and DEPTH,
// RAM contents undefined; there is no clearing pass.
// ----------------------------------------------------------------------------
module two_stacks_shared_memory #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsm_in_if.sink     in_i,
  tsm_out_if.source  out_o,
  tsm_cfg_if.sink    cfg_i
);
  import tsm_pkg::*;

  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned RST_CAP = (DEPTH < 1024) ? DEPTH : 1024;

  typedef struct packed {
    logic    valid;
    logic    take;
    status_e status;
  } res_meta_t;

  logic [CNT_W-1:0] cap_q, cap_d;
  logic [CNT_W-1:0] low_q, low_d;
  logic [CNT_W-1:0] high_q, high_d;
  res_meta_t        meta_q, meta_d;

  logic                  accept;
  logic                  cfg_accept;
  logic                  ram_en;
  logic                  ram_we;
  logic [CNT_W-1:0]      ram_addr_full;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic [63:0]           wdata_wide;
  logic [63:0]           rdata_wide;

  assign in_i.ready  = !meta_q.valid || out_o.ready;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;
  assign cfg_accept  = cfg_i.valid && cfg_i.ready;

  assign wdata_wide = 64'(in_i.push_value);
  assign ram_wdata  = wdata_wide[DATA_WIDTH-1:0];

  always_comb begin
    cap_d         = cap_q;
    low_d         = low_q;
    high_d        = high_q;
    meta_d        = meta_q;
    ram_en        = 1'b0;
    ram_we        = 1'b0;
    ram_addr_full = low_q;
    if (out_o.ready) begin
      meta_d.valid = 1'b0;
    end
    if (accept) begin
      meta_d.valid  = 1'b1;
      meta_d.take   = 1'b0;
      meta_d.status = ST_OK;
      if (in_i.cmd == CMD_PUSH) begin
        if (low_q < high_q) begin
          ram_en = 1'b1;
          ram_we = 1'b1;
          if (in_i.stack_sel == SEL_LOW) begin
            ram_addr_full = low_q;
            low_d         = low_q + CNT_W'(1);
          end else begin
            ram_addr_full = high_q - CNT_W'(1);
            high_d        = high_q - CNT_W'(1);
          end
        end else begin
          meta_d.status = ST_FULL;
        end
      end else if (in_i.stack_sel == SEL_LOW) begin
        if (low_q != '0) begin
          ram_en        = 1'b1;
          meta_d.take   = 1'b1;
          ram_addr_full = low_q - CNT_W'(1);
          low_d         = low_q - CNT_W'(1);
        end else begin
          meta_d.status = ST_EMPTY;
        end
      end else begin
        if (high_q < cap_q) begin
          ram_en        = 1'b1;
          meta_d.take   = 1'b1;
          ram_addr_full = high_q;
          high_d        = high_q + CNT_W'(1);
        end else begin
          meta_d.status = ST_EMPTY;
        end
      end
    end
    if (cfg_accept) begin
      if (32'(cfg_i.capacity) > 32'(DEPTH)) begin
        cap_d = CNT_W'(DEPTH);
      end else begin
        cap_d = CNT_W'(cfg_i.capacity);
      end
      low_d  = '0;
      high_d = cap_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q         <= CNT_W'(RST_CAP);
      low_q         <= '0;
      high_q        <= CNT_W'(RST_CAP);
      meta_q.valid  <= 1'b0;
      meta_q.take   <= 1'b0;
      meta_q.status <= ST_OK;
    end else begin
      cap_q  <= cap_d;
      low_q  <= low_d;
      high_q <= high_d;
      meta_q <= meta_d;
    end
  end

  tsm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr_full[AW-1:0]),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign rdata_wide      = 64'(ram_rdata);
  assign out_o.valid     = meta_q.valid;
  assign out_o.status    = meta_q.status;
  assign out_o.pop_value = meta_q.take ? rdata_wide[OUT_W-1:0] : '0;

  a_low_below_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_q <= high_q)
    else $error("stack one top passed stack two top");

  a_high_within_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    high_q <= cap_q)
    else $error("stack two base above capacity");

  a_cap_within_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cap_q) <= 32'(DEPTH))
    else $error("capacity above memory depth");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> meta_q.valid)
    else $error("accepted word produced no result");

  a_take_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meta_q.valid && meta_q.take |-> meta_q.status == ST_OK)
    else $error("memory data returned with an error status");

endmodule
